// ===== rtl/rcfe_pkg.sv =====
// Shared types, constants and the CRC function of the credential frame encoder.
`default_nettype none

package rcfe_pkg;

	localparam int unsigned FrameBits = 96;
	localparam int unsigned WordBits = 32;
	localparam int unsigned NumBytes = 8;
	localparam int unsigned MsgBits = 64;

	localparam logic [15:0] Preamble = 16'h7FEA;
	localparam logic [7:0] CrcPoly = 8'h07;
	localparam logic [7:0] CrcInit = 8'h2C;
	localparam logic [1:0] LastIdx = 2'd2;

	typedef struct packed {
		logic [3:0]  region_code;
		logic [3:0]  issue_level;
		logic [15:0] facility_code;
		logic [23:0] card_number;
	} cred_t;

	localparam logic [7:0] Sbox [256] = '{
		8'ha3, 8'hb0, 8'h80, 8'hc6, 8'hb2, 8'hf4, 8'h5c, 8'h6c, 8'h81, 8'hf1, 8'hbb, 8'heb,
		8'h55, 8'h67, 8'h3c, 8'h05, 8'h1a, 8'h0e, 8'h61, 8'hf6, 8'h22, 8'hce, 8'haa, 8'h8f,
		8'hbd, 8'h3b, 8'h1f, 8'h5e, 8'h44, 8'h04, 8'h51, 8'h2e, 8'h4d, 8'h9a, 8'h84, 8'hea,
		8'hf8, 8'h66, 8'h74, 8'h29, 8'h7f, 8'h70, 8'hd8, 8'h31, 8'h7a, 8'h6d, 8'ha4, 8'h00,
		8'h82, 8'hb9, 8'h5f, 8'hb4, 8'h16, 8'hab, 8'hff, 8'hc2, 8'h39, 8'hdc, 8'h19, 8'h65,
		8'h57, 8'h7c, 8'h20, 8'hfa, 8'h5a, 8'h49, 8'h13, 8'hd0, 8'hfb, 8'ha8, 8'h91, 8'h73,
		8'hb1, 8'h33, 8'h18, 8'hbe, 8'h21, 8'h72, 8'h48, 8'hb6, 8'hdb, 8'ha0, 8'h5d, 8'hcc,
		8'he6, 8'h17, 8'h27, 8'he5, 8'hd4, 8'h53, 8'h42, 8'hf3, 8'hdd, 8'h7b, 8'h24, 8'hac,
		8'h2b, 8'h58, 8'h1e, 8'ha7, 8'he7, 8'h86, 8'h40, 8'hd3, 8'h98, 8'h97, 8'h71, 8'hcb,
		8'h3a, 8'h0f, 8'h01, 8'h9b, 8'h6e, 8'h1b, 8'hfc, 8'h34, 8'ha6, 8'hda, 8'h07, 8'h0c,
		8'hae, 8'h37, 8'hca, 8'h54, 8'hfd, 8'h26, 8'hfe, 8'h0a, 8'h45, 8'ha2, 8'h2a, 8'hc4,
		8'h12, 8'h0d, 8'hf5, 8'h4f, 8'h69, 8'he0, 8'h8a, 8'h77, 8'h60, 8'h3f, 8'h99, 8'h95,
		8'hd2, 8'h38, 8'h36, 8'h62, 8'hb7, 8'h32, 8'h7e, 8'h79, 8'hc0, 8'h46, 8'h93, 8'h2f,
		8'ha5, 8'hba, 8'h5b, 8'haf, 8'h52, 8'h1d, 8'hc3, 8'h75, 8'hcf, 8'hd6, 8'h4c, 8'h83,
		8'he8, 8'h3d, 8'h30, 8'h4e, 8'hbc, 8'h08, 8'h2d, 8'h09, 8'h06, 8'hd9, 8'h25, 8'h9e,
		8'h89, 8'hf2, 8'h96, 8'h88, 8'hc1, 8'h8c, 8'h94, 8'h0b, 8'h28, 8'hf0, 8'h47, 8'h63,
		8'hd5, 8'hb3, 8'h68, 8'h56, 8'h9c, 8'hf9, 8'h6f, 8'h41, 8'h50, 8'h85, 8'h8b, 8'h9d,
		8'h59, 8'hbf, 8'h9f, 8'he2, 8'h8e, 8'h6a, 8'h11, 8'h23, 8'ha1, 8'hcd, 8'hb5, 8'h7d,
		8'hc7, 8'ha9, 8'hc8, 8'hef, 8'hdf, 8'h02, 8'hb8, 8'h03, 8'h6b, 8'h35, 8'h3e, 8'h2c,
		8'h76, 8'hc9, 8'hde, 8'h1c, 8'h4b, 8'hd1, 8'hed, 8'h14, 8'hc5, 8'had, 8'he9, 8'h64,
		8'h4a, 8'hec, 8'h8d, 8'hf7, 8'h10, 8'h43, 8'h78, 8'h15, 8'h87, 8'he4, 8'hd7, 8'h92,
		8'he1, 8'hee, 8'he3, 8'h90
	};

	// Run n zero message bits through the CRC register (n is always a constant here).
	function automatic logic [7:0] crc8_shift(input logic [7:0] c, input int unsigned n);
		logic [7:0] r;
		r = c;
		for (int unsigned k = 0; k < MsgBits; k++) begin
			if (k < n) begin
				r = r[7] ? ({r[6:0], 1'b0} ^ CrcPoly) : {r[6:0], 1'b0};
			end
		end
		return r;
	endfunction

	// CRC is linear: XOR of the init term and one constant column per set message bit.
	function automatic logic [7:0] crc8_msg(input logic [MsgBits-1:0] m);
		logic [7:0] c;
		c = crc8_shift(CrcInit, MsgBits);
		for (int unsigned p = 0; p < MsgBits; p++) begin
			if (m[MsgBits-1-p]) begin
				c = c ^ crc8_shift(CrcPoly, MsgBits - 1 - p);
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rcfe_cred_if.sv =====
// Credential request channel: valid/ready handshake with the credential fields.
`default_nettype none

interface rcfe_cred_if;
	logic        valid;
	logic        ready;
	logic [3:0]  region_code;
	logic [3:0]  issue_level;
	logic [15:0] facility_code;
	logic [23:0] card_number;

	modport source (output valid, region_code, issue_level, facility_code, card_number,
		input ready);
	modport sink (input valid, region_code, issue_level, facility_code, card_number,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/rcfe_word_if.sv =====
// Frame word channel: valid/ready handshake with one 32-bit word of the frame.
`default_nettype none

interface rcfe_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] frame_word;
	logic [1:0]  word_index;
	logic        last_word;

	modport source (output valid, frame_word, word_index, last_word, input ready);
	modport sink (input valid, frame_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/rcfe_frame_build.sv =====
// Packs a credential, scrambles the bytes, adds stuff bits, preamble and CRC-8.
`default_nettype none

module rcfe_frame_build (
	input  var rcfe_pkg::cred_t               cred,
	output logic [rcfe_pkg::FrameBits-1:0]    frame
);

	logic [7:0] pay [rcfe_pkg::NumBytes];
	logic [7:0] scr [rcfe_pkg::NumBytes];
	logic [rcfe_pkg::MsgBits-1:0] msg;
	logic [7:0] crc;

	always_comb begin
		pay[0] = cred.card_number[23:16];
		pay[1] = cred.facility_code[11:4];
		pay[2] = cred.card_number[10:3];
		pay[3] = {cred.card_number[2:0], cred.region_code, 1'b0};
		pay[4] = {3'b000, cred.card_number[15:11]};
		pay[5] = {4'b0000, cred.facility_code[15:12]};
		pay[6] = 8'h00;
		pay[7] = {cred.facility_code[3:0], cred.issue_level};
	end

	always_comb begin
		for (int i = 0; i < rcfe_pkg::NumBytes; i++) begin
			scr[i] = rcfe_pkg::Sbox[pay[i]];
		end
	end

	always_comb begin
		for (int i = 0; i < rcfe_pkg::NumBytes; i++) begin
			msg[rcfe_pkg::MsgBits-1-8*i -: 8] = scr[i];
		end
	end

	assign crc = rcfe_pkg::crc8_msg(msg);

	// preamble, then byte + inverted lsb nine times eight, then the CRC
	always_comb begin
		frame[rcfe_pkg::FrameBits-1 -: 16] = rcfe_pkg::Preamble;
		for (int i = 0; i < rcfe_pkg::NumBytes; i++) begin
			frame[rcfe_pkg::FrameBits-17-9*i -: 9] = {scr[i], ~scr[i][0]};
		end
		frame[7:0] = crc;
	end

endmodule

`default_nettype wire

// ===== rtl/rcfe_word_seq.sv =====
// Result register: holds one frame and hands it out as three words.
`default_nettype none

module rcfe_word_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load_valid,
	output logic                            load_ready,
	input  logic [rcfe_pkg::FrameBits-1:0]  load_frame,
	rcfe_word_if.source                     frame
);

	logic [rcfe_pkg::FrameBits-1:0] frame_q;
	logic [1:0]                     idx_q;
	logic                           valid_q;
	logic                           take;
	logic                           done;

	assign take = frame.valid && frame.ready;
	assign done = take && (idx_q == rcfe_pkg::LastIdx);
	// the next frame enters in the cycle that the last word leaves
	assign load_ready = !valid_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load_valid && load_ready) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (done) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			frame_q <= load_frame;
		end else if (take) begin
			frame_q <= frame_q << rcfe_pkg::WordBits;
		end
	end

	assign frame.valid      = valid_q;
	assign frame.frame_word = frame_q[rcfe_pkg::FrameBits-1 -: rcfe_pkg::WordBits];
	assign frame.word_index = idx_q;
	assign frame.last_word  = (idx_q == rcfe_pkg::LastIdx);

endmodule

`default_nettype wire

// ===== rtl/rfid_credential_frame_encoder_core.sv =====
// Top level of the credential frame encoder: input register, frame logic, word output.
`default_nettype none

// Each credential request becomes a 96-bit frame (preamble 0x7FEA, eight
// scrambled bytes each followed by its inverted lsb, CRC-8) sent as three
// 32-bit words, first frame bit in bit 31 of word 0. A request is registered,
// the frame is built by combinational logic into the output register, and that
// register then delivers one word per cycle while the sink is ready, so a
// credential takes the three words of the output register. A request passes
// the input register and then the output register before its first word
// appears. A new request is taken while the previous frame is still being sent.
module rfid_credential_frame_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	rcfe_cred_if.sink   cred,
	rcfe_word_if.source frame
);

	rcfe_pkg::cred_t                cred_s1;
	logic                           valid_s1;
	logic                           seq_ready;
	logic [rcfe_pkg::FrameBits-1:0] built;

	assign cred.ready = !valid_s1 || seq_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cred.ready) begin
			valid_s1 <= cred.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cred.valid && cred.ready) begin
			cred_s1 <= '{region_code:   cred.region_code,
			             issue_level:   cred.issue_level,
			             facility_code: cred.facility_code,
			             card_number:   cred.card_number};
		end
	end

	rcfe_frame_build u_build (
		.cred  (cred_s1),
		.frame (built)
	);

	rcfe_word_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_ready (seq_ready),
		.load_frame (built),
		.frame      (frame)
	);

	// an accepted request is held in the input register next cycle
	a_req_held: assert property (@(posedge clk) disable iff (!arst_n)
		cred.valid && cred.ready |=> valid_s1)
		else $error("accepted request not registered");

	// words of one frame follow in index order
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && frame.ready && !frame.last_word |=>
			frame.valid && (frame.word_index == $past(frame.word_index) + 2'd1))
		else $error("frame word out of order");

	// the first word always opens with the preamble
	a_preamble: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && (frame.word_index == 2'd0) |->
			frame.frame_word[31:16] == rcfe_pkg::Preamble)
		else $error("preamble missing on first word");

	// the input register waits while the output register is busy with a frame
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !seq_ready |=> valid_s1 && $stable(cred_s1))
		else $error("pending request lost");

endmodule

`default_nettype wire
